// ----- hdl/nrs_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nrs_pkg
// Shared types and constants for the nonzero run segmenter.
// ----------------------------------------------------------------------------
package nrs_pkg;

  localparam int unsigned POS_BITS_DEFAULT = 32;
  localparam int unsigned QUEUE_DEPTH      = 4;
  localparam int unsigned FIELD_BITS       = 32;

  // Mask for bits 30..0: a sample is zero when these are clear (+0 and -0).
  localparam logic [31:0] MAG_MASK = 32'h7FFF_FFFF;

  typedef struct packed {
    logic [31:0] sample;
    logic        last;
  } seg_in_t;

  typedef struct packed {
    logic [31:0] seg_start;
    logic [31:0] seg_stop;
    logic        last_of_run;
  } seg_out_t;

  // One queue entry holds every result caused by one input transaction.
  typedef struct packed {
    logic     split_vld;
    seg_out_t split_res;
    logic     close_vld;
    seg_out_t close_res;
  } nrs_entry_t;

endpackage

// ----- hdl/nonzero_run_segmenter_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nonzero_run_segmenter_top
// Cuts a contig's trace of float samples into segments at zero samples.
// ----------------------------------------------------------------------------
// The block takes one sample per cycle, in position order, and reports
// segments [seg_start, seg_stop) of one contig. A sample is zero when bits
// 30..0 of its single-precision pattern are clear. A zero sample at least
// min_segment_length positions past the open segment start closes that
// segment and opens a new one at its own position; the sample flagged last
// closes the contig with a segment ending at its position plus one, then
// the block starts over at position zero. One input transaction yields zero,
// one or two output transactions; on two, the second carries last_of_run.
// Input is taken every cycle as long as the four-entry result queue has
// room; the output side drains one result per cycle while out_stall_i is
// low, so an item with two results takes two output transactions and the
// queue absorbs such bursts. Positions saturate at 2^POS_BITS - 1 and
// are reported in 32 bits. Write min_segment_length (a value of zero
// acts as one) only while the block is idle.
// ----------------------------------------------------------------------------
module nonzero_run_segmenter_top
  import nrs_pkg::*;
#(
  parameter int unsigned POS_BITS    = POS_BITS_DEFAULT,
  parameter int unsigned QUEUE_DEPTH_P = QUEUE_DEPTH
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration: min_segment_length
  input  logic        cfg_we_i,
  input  logic [31:0] cfg_wdata_i,
  // sample stream
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  seg_in_t     in_data_i,
  // segment stream
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output seg_out_t    out_data_o
);

  logic       push;
  nrs_entry_t push_data;
  logic       q_full;
  logic       pop;
  logic       q_valid;
  nrs_entry_t q_data;

  // Classify each sample and advance position; build the result entry.
  nrs_front #(
    .POS_BITS (POS_BITS)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .q_full_i    (q_full),
    .push_o      (push),
    .push_data_o (push_data)
  );

  // Decouple sample intake from output backpressure.
  nrs_queue #(
    .DEPTH (QUEUE_DEPTH_P)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .full_o      (q_full),
    .pop_i       (pop),
    .valid_o     (q_valid),
    .pop_data_o  (q_data)
  );

  // Unroll each entry into one or two output transactions.
  nrs_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_data_i    (q_data),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

// ----- hdl/nrs_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nrs_front
// Accepts samples, tracks position and open segment start, and forms the
// results of each transaction as one queue entry.
// ----------------------------------------------------------------------------
module nrs_front
  import nrs_pkg::*;
#(
  parameter int unsigned POS_BITS = POS_BITS_DEFAULT
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [31:0] cfg_wdata_i,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  seg_in_t    in_data_i,
  input  logic       q_full_i,
  output logic       push_o,
  output nrs_entry_t push_data_o
);

  localparam int unsigned CMP_BITS = (POS_BITS > FIELD_BITS) ? POS_BITS : FIELD_BITS;

  logic [31:0]         min_len_q;
  logic [POS_BITS-1:0] position_q, position_d;
  logic [POS_BITS-1:0] open_start_q, open_start_d;

  logic                accept;
  logic                is_zero;
  logic                split;
  logic [POS_BITS-1:0] diff;
  logic [POS_BITS-1:0] pos_inc;
  logic [CMP_BITS-1:0] diff_ext;
  logic [CMP_BITS-1:0] min_ext;
  logic [CMP_BITS-1:0] pos_ext;
  logic [CMP_BITS-1:0] inc_ext;
  logic [CMP_BITS-1:0] open_ext;
  logic [CMP_BITS-1:0] close_start_ext;

  assign in_stall_o = q_full_i;
  assign accept     = in_valid_i && !q_full_i;

  assign is_zero  = (in_data_i.sample & MAG_MASK) == '0;
  assign diff     = position_q - open_start_q;
  assign diff_ext = CMP_BITS'(diff);
  // Treat a minimum of zero as one.
  assign min_ext  = (min_len_q == '0) ? CMP_BITS'(1) : CMP_BITS'(min_len_q);
  assign split    = is_zero && (diff_ext >= min_ext);

  // Saturate at the top of the position range.
  assign pos_inc = (&position_q) ? position_q : position_q + POS_BITS'(1);

  assign pos_ext         = CMP_BITS'(position_q);
  assign inc_ext         = CMP_BITS'(pos_inc);
  assign open_ext        = CMP_BITS'(open_start_q);
  assign close_start_ext = split ? pos_ext : open_ext;

  always_comb begin
    push_data_o.split_vld             = split;
    push_data_o.split_res.seg_start   = open_ext[31:0];
    push_data_o.split_res.seg_stop    = pos_ext[31:0];
    push_data_o.split_res.last_of_run = !in_data_i.last;
    push_data_o.close_vld             = in_data_i.last;
    push_data_o.close_res.seg_start   = close_start_ext[31:0];
    push_data_o.close_res.seg_stop    = inc_ext[31:0];
    push_data_o.close_res.last_of_run = 1'b1;
  end

  // Push only transactions that produce at least one result.
  assign push_o = accept && (split || in_data_i.last);

  always_comb begin
    position_d   = position_q;
    open_start_d = open_start_q;
    if (accept) begin
      if (in_data_i.last) begin
        position_d   = '0;
        open_start_d = '0;
      end else begin
        position_d = pos_inc;
        if (split) begin
          open_start_d = position_q;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_len_q    <= 32'd1;
      position_q   <= '0;
      open_start_q <= '0;
    end else begin
      if (cfg_we_i) begin
        min_len_q <= cfg_wdata_i;
      end
      position_q   <= position_d;
      open_start_q <= open_start_d;
    end
  end

endmodule

// ----- hdl/nrs_queue.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nrs_queue
// Short register FIFO between the front and the back.
// ----------------------------------------------------------------------------
module nrs_queue
  import nrs_pkg::*;
#(
  parameter int unsigned DEPTH = QUEUE_DEPTH
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push_i,
  input  nrs_entry_t push_data_i,
  output logic       full_o,
  input  logic       pop_i,
  output logic       valid_o,
  output nrs_entry_t pop_data_o
);

  localparam int unsigned PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_BITS = $clog2(DEPTH + 1);

  nrs_entry_t          mem_q [DEPTH];
  logic [PTR_BITS-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_BITS-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_BITS-1:0] count_q, count_d;
  logic                do_push;
  logic                do_pop;

  assign full_o     = (count_q == CNT_BITS'(DEPTH));
  assign valid_o    = (count_q != '0);
  assign pop_data_o = mem_q[rd_ptr_q];
  assign do_push    = push_i && !full_o;
  assign do_pop     = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PTR_BITS'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_BITS'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_BITS'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_BITS'(1);
    end
    if (do_push && !do_pop) begin
      count_d = count_q + CNT_BITS'(1);
    end else if (do_pop && !do_push) begin
      count_d = count_q - CNT_BITS'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

// ----- hdl/nrs_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nrs_back
// Drains queue entries and presents their results one per output
// transaction from a registered output.
// ----------------------------------------------------------------------------
module nrs_back
  import nrs_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       q_valid_i,
  input  nrs_entry_t q_data_i,
  output logic       pop_o,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output seg_out_t   out_data_o
);

  logic     out_valid_q, out_valid_d;
  seg_out_t out_q, out_d;
  logic     second_vld_q, second_vld_d;
  seg_out_t second_q, second_d;
  logic     load_ok;

  assign load_ok = !out_valid_q || !out_stall_i;
  assign pop_o   = load_ok && !second_vld_q && q_valid_i;

  always_comb begin
    out_valid_d  = out_valid_q;
    out_d        = out_q;
    second_vld_d = second_vld_q;
    second_d     = second_q;
    if (load_ok) begin
      if (second_vld_q) begin
        // Emit the closing result held back behind a split.
        out_valid_d  = 1'b1;
        out_d        = second_q;
        second_vld_d = 1'b0;
      end else if (q_valid_i) begin
        out_valid_d  = 1'b1;
        out_d        = q_data_i.split_vld ? q_data_i.split_res : q_data_i.close_res;
        second_vld_d = q_data_i.split_vld && q_data_i.close_vld;
        second_d     = q_data_i.close_res;
      end else begin
        out_valid_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      second_vld_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      second_vld_q <= second_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q    <= out_d;
    second_q <= second_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule
